// ===== rtl/core/lr_pkg.sv =====
package lr_pkg;

	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} lr_op_t;

	// controller to datapath
	typedef struct packed {
		logic start_line;
		logic step_line;
		logic div_go;
	} lr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic zero_len;
		logic div_done;
		logic last_step;
		logic out_free;
	} lr_status_t;

endpackage

// ===== rtl/core/lr_div.sv =====
module lr_div #(
	parameter int DVD_W = 29,
	parameter int DVS_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             fits;

	// restoring division, one quotient bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a run");

endmodule

// ===== rtl/core/lr_datapath.sv =====
module lr_datapath #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lr_pkg::lr_cmd_t         cmd,
	output lr_pkg::lr_status_t      status,
	input  logic [COORD_BITS-1:0]   x_start,
	input  logic [COORD_BITS-1:0]   y_start,
	input  logic [COORD_BITS-1:0]   x_end,
	input  logic [COORD_BITS-1:0]   y_end,
	input  logic [7:0]              color,
	input  logic                    m_tready,
	output logic                    m_tvalid,
	output logic [COORD_BITS-1:0]   pixel_x,
	output logic [COORD_BITS-1:0]   pixel_y,
	output logic [7:0]              pixel_color,
	output logic                    last_pixel
);
	import lr_pkg::*;

	localparam int C     = COORD_BITS;
	localparam int F     = FRAC_BITS;
	localparam int DVD_W = C + 1 + F;
	localparam int DVS_W = C + 1;
	localparam int ACC_W = C + F + 1;

	logic signed [C:0]   dx, dy, lng, sht;
	logic [C:0]          adx, ady, alng, asht;
	logic                y_maj;
	logic [DVD_W-1:0]    quo;
	logic                div_done;

	logic                y_major_q;
	logic                step_down_q;
	logic                neg_inc_q;
	logic [C-1:0]        maj_q;
	logic [C:0]          cnt_q;
	logic [ACC_W-1:0]    acc_q;
	logic [F+1:0]        inc_q;
	logic [7:0]          color_q;

	logic                out_valid_q;
	logic [C-1:0]        px_q, py_q;
	logic [7:0]          pcolor_q;
	logic                plast_q;

	logic [C-1:0]        maj_next;
	logic [ACC_W-1:0]    acc_next;
	logic [C-1:0]        min_next;
	logic [F+1:0]        q_ext;

	// start geometry
	always_comb begin
		dx    = $signed({x_end[C-1], x_end}) - $signed({x_start[C-1], x_start});
		dy    = $signed({y_end[C-1], y_end}) - $signed({y_start[C-1], y_start});
		adx   = dx[C] ? -dx : dx;
		ady   = dy[C] ? -dy : dy;
		y_maj = ady > adx;
		lng   = y_maj ? dy : dx;
		sht   = y_maj ? dx : dy;
		alng  = y_maj ? ady : adx;
		asht  = y_maj ? adx : ady;
	end

	lr_div #(
		.DVD_W(DVD_W),
		.DVS_W(DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend ({asht, {F{1'b0}}}),
		.divisor  (alng),
		.done     (div_done),
		.quotient (quo)
	);

	// next pixel along the line
	always_comb begin
		maj_next = step_down_q ? maj_q - 1'b1 : maj_q + 1'b1;
		acc_next = acc_q + {{(ACC_W-F-2){inc_q[F+1]}}, inc_q};
		min_next = acc_next[F +: C];
		q_ext    = {1'b0, quo[F:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cmd.start_line) begin
				out_valid_q <= 1'b1;
				cnt_q       <= alng;
			end else if (cmd.step_line) begin
				out_valid_q <= 1'b1;
				cnt_q       <= cnt_q - 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_line) begin
			y_major_q   <= y_maj;
			step_down_q <= lng[C];
			neg_inc_q   <= sht[C];
			maj_q       <= y_maj ? y_start : x_start;
			acc_q       <= y_maj ? {x_start[C-1], x_start, {F{1'b0}}}
			                     : {y_start[C-1], y_start, {F{1'b0}}};
			inc_q       <= '0;
			color_q     <= color;
			px_q        <= x_start;
			py_q        <= y_start;
			pcolor_q    <= color;
			plast_q     <= alng == '0;
		end else begin
			if (div_done) begin
				inc_q <= neg_inc_q ? -q_ext : q_ext;
			end
			if (cmd.step_line) begin
				maj_q    <= maj_next;
				acc_q    <= acc_next;
				px_q     <= y_major_q ? min_next : maj_next;
				py_q     <= y_major_q ? maj_next : min_next;
				pcolor_q <= color_q;
				plast_q  <= cnt_q == (C+1)'(1);
			end
		end
	end

	always_comb begin
		status.zero_len  = alng == '0;
		status.div_done  = div_done;
		status.last_step = cnt_q == (C+1)'(1);
		status.out_free  = !out_valid_q || m_tready;
	end

	assign m_tvalid    = out_valid_q;
	assign pixel_x     = px_q;
	assign pixel_y     = py_q;
	assign pixel_color = pcolor_q;
	assign last_pixel  = plast_q;

	a_step_has_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step_line |-> cnt_q != '0)
		else $error("step past the end of the line");

	a_point_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_line && status.zero_len |=> out_valid_q && plast_q)
		else $error("single point not flagged last");

endmodule

// ===== rtl/core/lr_ctrl.sv =====
module lr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tuser,
	output logic               s_tready,
	input  lr_pkg::lr_status_t status,
	output lr_pkg::lr_cmd_t    cmd
);
	import lr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   take;

	always_comb begin
		s_tready       = (state_q != ST_DIV) && status.out_free;
		take           = s_tvalid && s_tready;
		cmd.start_line = take && (s_tuser == OP_START);
		cmd.step_line  = take && (s_tuser == OP_STEP) && (state_q == ST_RUN);
		cmd.div_go     = cmd.start_line && !status.zero_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			priority if (cmd.start_line) begin
				state_q <= status.zero_len ? ST_IDLE : ST_DIV;
			end else if (state_q == ST_DIV && status.div_done) begin
				state_q <= ST_RUN;
			end else if (cmd.step_line && status.last_step) begin
				state_q <= ST_IDLE;
			end
		end
	end

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> state_q == ST_DIV)
		else $error("division finished outside the divide state");

	a_div_to_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && status.div_done |=> state_q == ST_RUN)
		else $error("line not running after division");

endmodule

// ===== rtl/core/line_rasterizer.sv =====
// line rasterizer, fixed-point dda
// slave channel: one transaction per command. s_tuser is the op: 0 starts a
// line from (x_start, y_start) to (x_end, y_end) in the given color and
// emits its first pixel, 1 emits the next pixel of the active line.
// a step command with no active line is taken and emits nothing.
// master channel: one transaction per pixel, m_tlast marks the final pixel
// of the line (a single point is its own last pixel).
// latency: a pixel appears on the master side the cycle after its command.
// throughput: step commands go at one per cycle while the receiver takes
// pixels. after a start command for a line of nonzero length, the slave
// side is held off while the bit-serial divider forms the minor-axis
// increment.
// a start command during an active line drops that line.
// when the receiver stalls, the pixel holds in the output register and the
// slave side stops until it is taken.
// reset clears the controller to idle and empties the output register.
module line_rasterizer #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// x_start, y_start, x_end, y_end, color
	input  logic [((4*COORD_BITS+8+7)/8)*8-1:0]    s_tdata,
	// op
	input  logic                                   s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// pixel_x, pixel_y, pixel_color
	output logic [((2*COORD_BITS+8+7)/8)*8-1:0]    m_tdata,
	output logic                                   m_tlast
);
	import lr_pkg::*;

	localparam int C     = COORD_BITS;
	localparam int OUT_W = ((2*COORD_BITS+8+7)/8)*8;

	lr_cmd_t      cmd;
	lr_status_t   status;
	logic [C-1:0] pixel_x, pixel_y;
	logic [7:0]   pixel_color;

	lr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lr_datapath #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.x_start     (s_tdata[0*C +: C]),
		.y_start     (s_tdata[1*C +: C]),
		.x_end       (s_tdata[2*C +: C]),
		.y_end       (s_tdata[3*C +: C]),
		.color       (s_tdata[4*C +: 8]),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (m_tlast)
	);

	assign m_tdata = OUT_W'({pixel_color, pixel_y, pixel_x});

endmodule

// ===== tb/tb_line_rasterizer.sv =====
`timescale 1ns / 1ps

module tb_line_rasterizer;
	import lr_pkg::*;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;
	localparam int S_W = ((4*COORD_BITS+8+7)/8)*8;
	localparam int M_W = ((2*COORD_BITS+8+7)/8)*8;
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_PIXELS = 400;
	localparam int N_DIRECTED = 24;

	typedef enum logic [1:0] {
		CHK_PREDICT,
		CHK_SILENT,
		CHK_PIXEL
	} check_t;

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [7:0]  color;
		logic        last;
	} pixel_t;

	typedef struct packed {
		lr_op_t             op;
		logic signed [11:0] x0;
		logic signed [11:0] y0;
		logic signed [11:0] x1;
		logic signed [11:0] y1;
		logic [7:0]         color;
		check_t             chk;
		logic signed [11:0] ex;
		logic signed [11:0] ey;
		logic [7:0]         ec;
		logic               el;
	} row_t;

	logic           clk;
	logic           arst_n;
	logic           s_tvalid;
	logic           s_tready;
	logic [S_W-1:0] s_tdata;
	logic           s_tuser;
	logic           m_tvalid;
	logic           m_tready;
	logic [M_W-1:0] m_tdata;
	logic           m_tlast;

	line_rasterizer #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	row_t directed_rows [0:N_DIRECTED-1] = '{
		'{OP_STEP,      0,     0,     0,     0, 8'h00, CHK_SILENT,      0,     0, 8'h00, 1'b0},
		'{OP_START,     0,     0,     0,     0, 8'h00, CHK_PIXEL,       0,     0, 8'h00, 1'b1},
		'{OP_STEP,     -1,    -1,    -1,    -1, 8'hff, CHK_SILENT,      0,     0, 8'h00, 1'b0},
		'{OP_START, -2048, -2048,  2047,  2047, 8'hff, CHK_PIXEL,   -2048, -2048, 8'hff, 1'b0},
		'{OP_STEP,      0,     0,     0,     0, 8'h00, CHK_PREDICT,     0,     0, 8'h00, 1'b0},
		'{OP_STEP,      0,     0,     0,     0, 8'h00, CHK_PREDICT,     0,     0, 8'h00, 1'b0},
		'{OP_START,  2047,  2047, -2048, -2048, 8'ha5, CHK_PIXEL,    2047,  2047, 8'ha5, 1'b0},
		'{OP_STEP,      0,     0,     0,     0, 8'h00, CHK_PREDICT,     0,     0, 8'h00, 1'b0},
		'{OP_START,  2047, -2048,  2047,  2047, 8'h5a, CHK_PIXEL,    2047, -2048, 8'h5a, 1'b0},
		'{OP_STEP,      0,     0,     0,     0, 8'h00, CHK_PREDICT,     0,     0, 8'h00, 1'b0},
		'{OP_START,     3,     1,     0,     2, 8'h01, CHK_PIXEL,       3,     1, 8'h01, 1'b0},
		'{OP_STEP,      0,     0,     0,     0, 8'h00, CHK_PREDICT,     0,     0, 8'h00, 1'b0},
		'{OP_STEP,      0,     0,     0,     0, 8'h00, CHK_PREDICT,     0,     0, 8'h00, 1'b0},
		'{OP_STEP,      0,     0,     0,     0, 8'h00, CHK_PREDICT,     0,     0, 8'h00, 1'b0},
		'{OP_STEP,      0,     0,     0,     0, 8'h00, CHK_SILENT,      0,     0, 8'h00, 1'b0},
		'{OP_START,     0,     0,    -2,    -5, 8'h80, CHK_PIXEL,       0,     0, 8'h80, 1'b0},
		'{OP_STEP,      0,     0,     0,     0, 8'h00, CHK_PREDICT,     0,     0, 8'h00, 1'b0},
		'{OP_STEP,      0,     0,     0,     0, 8'h00, CHK_PREDICT,     0,     0, 8'h00, 1'b0},
		'{OP_STEP,      0,     0,     0,     0, 8'h00, CHK_PREDICT,     0,     0, 8'h00, 1'b0},
		'{OP_STEP,      0,     0,     0,     0, 8'h00, CHK_PREDICT,     0,     0, 8'h00, 1'b0},
		'{OP_STEP,      0,     0,     0,     0, 8'h00, CHK_PREDICT,     0,     0, 8'h00, 1'b0},
		'{OP_START,    -7,     3,    -6,     3, 8'h7f, CHK_PIXEL,      -7,     3, 8'h7f, 1'b0},
		'{OP_STEP,      0,     0,     0,     0, 8'h00, CHK_PREDICT,     0,     0, 8'h00, 1'b0},
		'{OP_START,   100,  -100,   100,  -100, 8'hff, CHK_PIXEL,     100,  -100, 8'hff, 1'b1}
	};

	// line state of the predictor
	bit          line_busy;
	bit          y_major;
	bit          step_down;
	int          major_pos;
	int          end_pos;
	int          frac_acc;
	int          frac_inc;
	int          org_x;
	int          org_y;
	logic [7:0]  line_color;

	pixel_t pending_pixels[$];
	bit     quiet_phase;
	int     error_count;
	int     idle_cycles;
	int     lines_started;
	int     pixels_predicted;
	int     pixels_checked;
	int     idle_steps;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_wait();
		return quiet_phase ? 0 : int'($urandom_range(0, 6));
	endfunction

	function automatic bit predict_pixel(input lr_op_t op, input logic signed [11:0] xa,
			input logic signed [11:0] ya, input logic signed [11:0] xb,
			input logic signed [11:0] yb, input logic [7:0] color, output pixel_t px);
		int dx, dy, adx, ady, lng, sht, alng, minor;
		int unsigned mag, q;
		px = '0;
		if (op == OP_START) begin
			dx = int'(xb) - int'(xa);
			dy = int'(yb) - int'(ya);
			adx = dx < 0 ? -dx : dx;
			ady = dy < 0 ? -dy : dy;
			y_major = ady > adx;
			lng = y_major ? dy : dx;
			sht = y_major ? dx : dy;
			alng = lng < 0 ? -lng : lng;
			step_down = lng < 0;
			end_pos = lng;
			if (alng == 0) begin
				frac_inc = 0;
			end else begin
				mag = unsigned'(sht < 0 ? -sht : sht) << FRAC_BITS;
				q = mag / unsigned'(alng);
				frac_inc = sht < 0 ? -int'(q) : int'(q);
			end
			org_x = int'(xa);
			org_y = int'(ya);
			line_color = color;
			major_pos = 0;
			frac_acc = 0;
			line_busy = 1'b1;
		end else begin
			if (!line_busy)
				return 1'b0;
			major_pos += step_down ? -1 : 1;
			frac_acc += frac_inc;
		end
		minor = frac_acc >>> FRAC_BITS;
		px.x = y_major ? 12'(org_x + minor) : 12'(org_x + major_pos);
		px.y = y_major ? 12'(org_y + major_pos) : 12'(org_y + minor);
		px.color = line_color;
		px.last = (major_pos == end_pos);
		if (px.last)
			line_busy = 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [11:0] near_coord(input logic signed [11:0] base, input int span);
		int d, v;
		d = int'($urandom_range(0, 2*span)) - span;
		v = int'(base) + d;
		if (v > 2047 || v < -2048)
			v = int'(base) - d;
		return 12'(v);
	endfunction

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("ERROR: %s", msg);
	endtask

	task automatic send_cmd(input lr_op_t op, input logic [11:0] xa, input logic [11:0] ya,
			input logic [11:0] xb, input logic [11:0] yb, input logic [7:0] color,
			input check_t chk, input pixel_t typed_px);
		int gap;
		bit has_px;
		pixel_t px;
		gap = pick_wait();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {color, yb, xb, ya, xa};
		do @(posedge clk); while (!s_tready);
		has_px = predict_pixel(op, xa, ya, xb, yb, color, px);
		if (chk == CHK_PIXEL)
			pending_pixels.push_back(typed_px);
		else if (chk == CHK_PREDICT && has_px)
			pending_pixels.push_back(px);
		if (has_px)
			pixels_predicted++;
		if (op == OP_START)
			lines_started++;
		else if (!has_px)
			idle_steps++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
	endtask

	// stimulus
	initial begin
		row_t        r;
		pixel_t      typed_px;
		int          kind, span, steps_left, base_pixels;
		bit          paused;
		logic [11:0] xa, ya, xb, yb;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		quiet_phase = 1'b0;
		paused = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			r = directed_rows[i];
			typed_px = '{x: r.ex, y: r.ey, color: r.ec, last: r.el};
			send_cmd(r.op, r.x0, r.y0, r.x1, r.y1, r.color, r.chk, typed_px);
		end

		base_pixels = pixels_predicted;
		while (pixels_predicted - base_pixels < RANDOM_PIXELS) begin
			quiet_phase = ($urandom_range(0, 4) == 0);
			if (!paused && pixels_predicted - base_pixels >= RANDOM_PIXELS / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			kind = int'($urandom_range(0, 9));
			if (kind == 0) begin
				// stray step, ignored when no line is active
				send_cmd(OP_STEP, 12'($urandom), 12'($urandom), 12'($urandom),
					12'($urandom), 8'($urandom), CHK_PREDICT, '0);
			end else begin
				xa = 12'($urandom);
				ya = 12'($urandom);
				if ($urandom_range(0, 7) == 0) begin
					xb = 12'($urandom);
					yb = 12'($urandom);
					steps_left = int'($urandom_range(0, 8));
				end else begin
					span = int'($urandom_range(0, 24));
					xb = near_coord(xa, span);
					yb = near_coord(ya, span);
					steps_left = (kind == 1) ? int'($urandom_range(0, 4)) : 5000;
				end
				send_cmd(OP_START, xa, ya, xb, yb, 8'($urandom), CHK_PREDICT, '0);
				while (line_busy && steps_left > 0) begin
					send_cmd(OP_STEP, 12'($urandom), 12'($urandom), 12'($urandom),
						12'($urandom), 8'($urandom), CHK_PREDICT, '0);
					steps_left--;
				end
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (pending_pixels.size() != 0)
			note_error($sformatf("%0d pixels never arrived", pending_pixels.size()));
		$display("covered %0d lines, %0d pixels compared, %0d steps sent with no line active",
			lines_started, pixels_checked, idle_steps);
		$display("mismatches: %0d", error_count);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// pixel receiver and checker
	initial begin
		int     stall;
		pixel_t want;
		pixel_t got;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = pick_wait();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = '{x: m_tdata[11:0], y: m_tdata[23:12], color: m_tdata[31:24], last: m_tlast};
			pixels_checked++;
			if (pending_pixels.size() == 0) begin
				note_error($sformatf("unexpected pixel x=%0d y=%0d color=%02h last=%0b",
					$signed(got.x), $signed(got.y), got.color, got.last));
			end else begin
				want = pending_pixels.pop_front();
				if (got != want)
					note_error($sformatf({"pixel mismatch: expected x=%0d y=%0d color=%02h ",
						"last=%0b, got x=%0d y=%0d color=%02h last=%0b"},
						$signed(want.x), $signed(want.y), want.color, want.last,
						$signed(got.x), $signed(got.y), got.color, got.last));
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d pixels outstanding",
					STALL_LIMIT, pending_pixels.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

endmodule
